// File: rtl/fqtp_pkg.sv
// ----------------------------------------------------------------------------
// fqtp_pkg: shared definitions for the FASTQ quality trim parser.
// Holds the line limit, derived widths, character codes and status codes.
// ----------------------------------------------------------------------------
package fqtp_pkg;

    // Longest line that is tracked; column and run lengths saturate here.
    localparam int LINE_LIMIT = 1024;
    localparam int COL_W      = $clog2(LINE_LIMIT + 1);
    localparam int OFS_W      = $clog2(LINE_LIMIT);

    // Register file.
    localparam int THR_W    = 7;
    localparam int MINLEN_W = 11;
    localparam int CNT_W    = 32;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(33);
    localparam logic [MINLEN_W-1:0] MINLEN_RESET = MINLEN_W'(10);

    // Register index, taken from the word address bit.
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_MIN_LENGTH = 1'b1;

    // Character codes.
    localparam logic [7:0] CHAR_AT   = 8'h40;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;

    // Line numbers within a record.
    localparam logic [1:0] LINE_HEADER    = 2'd0;
    localparam logic [1:0] LINE_SEPARATOR = 2'd2;
    localparam logic [1:0] LINE_QUALITY   = 2'd3;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_BAD_HEADER    = 2'd1,
        STATUS_BAD_SEPARATOR = 2'd2
    } status_t;

endpackage

// File: rtl/fastq_quality_trim_parser.sv
// ----------------------------------------------------------------------------
// fastq_quality_trim_parser: FASTQ record parser with quality run search.
// Result path: the newline beat that ends a record is held in the input
// register, and its result beat is then loaded into the result register.
// Throughput: one byte beat per cycle; only a record-ending newline waits,
// and only while the previous result beat is still held by the consumer.
// Reset: synchronous active-low aresetn clears all control state and loads
// the register defaults (threshold 33, minimum length 10).
// ----------------------------------------------------------------------------
module fastq_quality_trim_parser
    import fqtp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,

    // Byte stream in.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_stream_byte,

    // Record results out.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [COL_W-1:0]      m_read_length,
    output logic [OFS_W-1:0]      m_read_offset,
    output logic                  m_too_short,
    output logic [CNT_W-1:0]      m_record_number
);

    // Configuration registers.
    logic [THR_W-1:0]    thr_reg;
    logic [MINLEN_W-1:0] minlen_reg;
    logic                cfg_write;

    // Input register.
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;

    // Parser state.
    logic [1:0]          line_index_reg;
    logic [COL_W-1:0]    column_reg;
    logic                in_run_reg;
    logic [OFS_W-1:0]    run_start_reg;
    logic [COL_W-1:0]    best_length_reg;
    logic [OFS_W-1:0]    best_start_reg;
    logic                header_bad_reg;
    logic                separator_bad_reg;
    logic                halted_reg;
    logic [CNT_W-1:0]    record_count_reg;

    // Result register.
    logic                m_valid_reg;
    status_t             status_reg;
    logic [COL_W-1:0]    length_reg;
    logic [OFS_W-1:0]    offset_reg;
    logic                too_short_reg;
    logic [CNT_W-1:0]    number_reg;

    // Datapath signals.
    logic                needs_slot;
    logic                proc_go;
    logic                col_zero;
    logic                is_lf;
    logic                on_quality;
    logic                good;
    logic                col_open;
    logic [COL_W-1:0]    run_len;
    logic                close_run;
    logic                better;
    logic [COL_W-1:0]    best_length_c;
    logic [OFS_W-1:0]    best_start_c;
    logic                header_bad_c;
    logic                separator_bad_c;
    logic                emit;
    logic                emit_error;
    status_t             status_c;

    // Register writes complete in the access phase; reads return the value.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_THRESHOLD:  prdata = DATA_W'(thr_reg);
            REG_MIN_LENGTH: prdata = DATA_W'(minlen_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= THR_RESET;
            minlen_reg <= MINLEN_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_THRESHOLD) begin
                thr_reg <= pwdata[THR_W-1:0];
            end else begin
                minlen_reg <= pwdata[MINLEN_W-1:0];
            end
        end
    end

    // The held byte waits only when it ends a record and the result slot is
    // still full; every other byte is processed at once.
    assign needs_slot = !halted_reg && is_lf && on_quality;
    assign proc_go    = in_valid_reg && (!needs_slot || !m_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_stream_byte;
        end
    end

    // Classify the byte and evaluate the run that it may close.
    assign col_zero   = (column_reg == '0);
    assign is_lf      = (in_byte_reg == CHAR_LF);
    assign on_quality = (line_index_reg == LINE_QUALITY);
    assign good       = on_quality && !is_lf && (in_byte_reg != CHAR_CR)
                        && !in_byte_reg[7] && (in_byte_reg[6:0] >= thr_reg);
    assign col_open   = (column_reg < COL_W'(LINE_LIMIT));
    assign run_len    = column_reg - COL_W'(run_start_reg);
    assign close_run  = on_quality && !good && in_run_reg;
    assign better     = close_run && (run_len > best_length_reg);

    assign best_length_c = better ? run_len       : best_length_reg;
    assign best_start_c  = better ? run_start_reg : best_start_reg;

    // Format checks on the first byte of the header and separator lines.
    assign header_bad_c    = header_bad_reg
                             || (col_zero && (line_index_reg == LINE_HEADER)
                                 && (in_byte_reg != CHAR_AT));
    assign separator_bad_c = separator_bad_reg
                             || (col_zero && (line_index_reg == LINE_SEPARATOR)
                                 && (in_byte_reg != CHAR_PLUS));

    assign emit       = proc_go && needs_slot;
    assign emit_error = header_bad_c || separator_bad_c;

    always_comb begin
        if (header_bad_c) begin
            status_c = STATUS_BAD_HEADER;
        end else if (separator_bad_c) begin
            status_c = STATUS_BAD_SEPARATOR;
        end else begin
            status_c = STATUS_OK;
        end
    end

    // Parser state update, one byte per cycle unless the held byte waits for the result slot; no update once halted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_index_reg    <= '0;
            column_reg        <= '0;
            in_run_reg        <= 1'b0;
            run_start_reg     <= '0;
            best_length_reg   <= '0;
            best_start_reg    <= '0;
            header_bad_reg    <= 1'b0;
            separator_bad_reg <= 1'b0;
            halted_reg        <= 1'b0;
            record_count_reg  <= '0;
        end else if (proc_go && !halted_reg) begin
            if (is_lf && on_quality) begin
                // End of record: start over, count it or stop on an error.
                line_index_reg    <= '0;
                column_reg        <= '0;
                in_run_reg        <= 1'b0;
                run_start_reg     <= '0;
                best_length_reg   <= '0;
                best_start_reg    <= '0;
                header_bad_reg    <= 1'b0;
                separator_bad_reg <= 1'b0;
                if (emit_error) begin
                    halted_reg <= 1'b1;
                end else begin
                    record_count_reg <= record_count_reg + 1'b1;
                end
            end else begin
                header_bad_reg    <= header_bad_c;
                separator_bad_reg <= separator_bad_c;
                best_length_reg   <= best_length_c;
                best_start_reg    <= best_start_c;
                if (is_lf) begin
                    line_index_reg <= line_index_reg + 2'd1;
                    column_reg     <= '0;
                    in_run_reg     <= 1'b0;
                end else begin
                    if (good && !in_run_reg && col_open) begin
                        in_run_reg    <= 1'b1;
                        run_start_reg <= column_reg[OFS_W-1:0];
                    end else if (close_run) begin
                        in_run_reg <= 1'b0;
                    end
                    if (col_open) begin
                        column_reg <= column_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Result register; it holds a beat until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            status_reg <= status_c;
            number_reg <= record_count_reg;
            if (emit_error) begin
                length_reg    <= '0;
                offset_reg    <= '0;
                too_short_reg <= 1'b0;
            end else begin
                length_reg    <= best_length_c;
                offset_reg    <= best_start_c;
                too_short_reg <= (best_length_c < minlen_reg);
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_read_length   = length_reg;
    assign m_read_offset   = offset_reg;
    assign m_too_short     = too_short_reg;
    assign m_record_number = number_reg;

    // An error result always halts the parser on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && emit_error |=> halted_reg)
        else $error("parser did not halt after an error result");

    // Once halted, the parser stays halted until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("parser left the halted state without reset");

    // No result is produced while halted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !emit)
        else $error("result produced while halted");

    // A run is only open on the quality line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_run_reg |-> (line_index_reg == LINE_QUALITY))
        else $error("run open outside the quality line");

    // Error results carry no run information.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg != STATUS_OK) |->
            (length_reg == '0) && (offset_reg == '0) && !too_short_reg)
        else $error("error result carries run data");

endmodule
